/* sv/afr_pkg.sv */
package afr_pkg;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_QUERY = 8'd63;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;

   localparam logic [7:0] MIN_LEN  = 8'd2;

   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_ADDR  = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_OURS  = 3'd3;
   localparam logic [2:0] PH_OTHER = 3'd4;

   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_INFO    = 2'd1;
   localparam logic [1:0] EV_CTS     = 2'd2;

   typedef struct packed {
      logic       hit;
      logic [1:0] event_res;
      logic [7:0] data_byte;
      logic [6:0] byte_index;
      logic [7:0] frame_length;
      logic       last;
   } result_type;

endpackage

/* sv/afr_req_if.sv */
interface afr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* sv/afr_rsp_if.sv */
interface afr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [7:0] data_byte;
   logic [6:0] byte_index;
   logic [7:0] frame_length;
   logic       last;

   modport source (output valid, output event_res, output data_byte, output byte_index,
                   output frame_length, output last, input ready);
   modport sink (input valid, input event_res, input data_byte, input byte_index,
                 input frame_length, input last, output ready);
endinterface

/* sv/addressed_frame_receiver_core.sv */
// Channel | Direction | Handshake   | Payload
// req     | in        | valid/ready | rx_byte
// rsp     | out       | valid/ready | event_res, data_byte, byte_index, frame_length, last
// csr     | in        | csr_we      | csr_wdata (device_id)
//
// One byte per cycle sustained while rsp does not stall; a byte's result reaches rsp
// through the input register, then the parser state update into the result register,
// and is held there until rsp takes it.
// Reset is synchronous and active high; device_id returns to 1, the parser to hunting.
// A stall on rsp holds the result register and, once the input register is full,
// drops req.ready; bytes that give no result still wait for a free result register.
module addressed_frame_receiver_core #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic       clock,
   input  logic       reset,
   afr_req_if.sink    req,
   afr_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   logic                in_vld_ff;
   logic [7:0]          in_byte_ff;
   logic                out_vld_ff, out_vld_in;
   afr_pkg::result_type out_ff;
   afr_pkg::result_type result;
   logic [7:0]          device_id_ff;
   logic                out_free;
   logic                process;

   assign out_free  = !out_vld_ff || rsp.ready;
   assign process   = in_vld_ff && out_free;
   assign req.ready = !in_vld_ff || process;

   afr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (process),
      .rx_byte   (in_byte_ff),
      .device_id (device_id_ff),
      .result    (result)
   );

   always_comb begin
      out_vld_in = out_vld_ff && !rsp.ready;
      if (process && result.hit) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         device_id_ff <= 8'd1;
      end else begin
         if (req.ready) begin
            in_vld_ff <= req.valid;
         end
         out_vld_ff <= out_vld_in;
         if (csr_we) begin
            device_id_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.rx_byte;
      end
      if (process && result.hit) begin
         out_ff <= result;
      end
   end

   assign rsp.valid        = out_vld_ff;
   assign rsp.event_res    = out_ff.event_res;
   assign rsp.data_byte    = out_ff.data_byte;
   assign rsp.byte_index   = out_ff.byte_index;
   assign rsp.frame_length = out_ff.frame_length;
   assign rsp.last         = out_ff.last;

`ifndef ASSERT_OFF
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !process |=> in_vld_ff && $stable(in_byte_ff))
      else $error("pending input byte lost while the result register was busy");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp.ready |=> out_vld_ff && $stable(out_ff))
      else $error("waiting result overwritten");

   a_cts_clean: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.event_res != afr_pkg::EV_PAYLOAD |->
         out_ff.data_byte == 8'd0 && out_ff.byte_index == 7'd0 && !out_ff.last)
      else $error("event result carries payload fields");
`endif

endmodule

/* sv/afr_parser.sv */
module afr_parser #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           rx_byte,
   input  logic [7:0]           device_id,
   output afr_pkg::result_type  result
);

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] recent0_ff, recent0_in;
   logic [7:0] recent1_ff, recent1_in;
   logic [7:0] recent2_ff, recent2_in;
   logic       ours_ff, ours_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] seen_ff, seen_in;
   logic [8:0] next_count;
   logic       fin;

   assign next_count = {1'b0, seen_ff} + 9'd1;
   assign fin        = next_count >= {1'b0, len_ff};

   always_comb begin
      phase_in   = phase_ff;
      recent0_in = recent0_ff;
      recent1_in = recent1_ff;
      recent2_in = recent2_ff;
      ours_in    = ours_ff;
      len_in     = len_ff;
      seen_in    = seen_ff;
      result     = '0;
      case (phase_ff)
         afr_pkg::PH_ADDR: begin
            ours_in  = (rx_byte == device_id) || (rx_byte == 8'd0);
            phase_in = afr_pkg::PH_LEN;
         end
         afr_pkg::PH_LEN: begin
            if ((rx_byte < afr_pkg::MIN_LEN) || (rx_byte > MAX_LEN)) begin
               len_in   = 8'd0;
               phase_in = afr_pkg::PH_HUNT;
            end else begin
               len_in   = rx_byte;
               seen_in  = 8'd0;
               phase_in = ours_ff ? afr_pkg::PH_OURS : afr_pkg::PH_OTHER;
            end
         end
         afr_pkg::PH_OURS: begin
            result.hit          = 1'b1;
            result.event_res    = afr_pkg::EV_PAYLOAD;
            result.data_byte    = rx_byte;
            result.byte_index   = seen_ff[6:0];
            result.frame_length = len_ff;
            result.last         = fin;
            if (fin) begin
               seen_in  = 8'd0;
               phase_in = afr_pkg::PH_HUNT;
            end else begin
               seen_in = next_count[7:0];
            end
         end
         afr_pkg::PH_OTHER: begin
            if (fin) begin
               seen_in             = 8'd0;
               phase_in            = afr_pkg::PH_HUNT;
               result.hit          = 1'b1;
               result.event_res    = afr_pkg::EV_CTS;
               result.frame_length = len_ff;
            end else begin
               seen_in = next_count[7:0];
            end
         end
         default: begin
            // Unused phase codes behave as hunting.
            phase_in   = afr_pkg::PH_HUNT;
            recent0_in = recent1_ff;
            recent1_in = recent2_ff;
            recent2_in = rx_byte;
            if ((recent2_ff == afr_pkg::CH_COLON) && (rx_byte == afr_pkg::CH_COLON)) begin
               recent0_in = 8'd0;
               recent1_in = 8'd0;
               recent2_in = 8'd0;
               phase_in   = afr_pkg::PH_ADDR;
            end else if ((recent1_ff == afr_pkg::CH_QUERY) && (recent2_ff == afr_pkg::CH_CR)
                         && (rx_byte == afr_pkg::CH_LF)) begin
               result.hit       = 1'b1;
               result.event_res = afr_pkg::EV_INFO;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= afr_pkg::PH_HUNT;
         recent0_ff <= 8'd0;
         recent1_ff <= 8'd0;
         recent2_ff <= 8'd0;
         ours_ff    <= 1'b0;
         len_ff     <= 8'd0;
         seen_ff    <= 8'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         recent0_ff <= recent0_in;
         recent1_ff <= recent1_in;
         recent2_ff <= recent2_in;
         ours_ff    <= ours_in;
         len_ff     <= len_in;
         seen_ff    <= seen_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      step && result.hit && result.last |=> phase_ff == afr_pkg::PH_HUNT)
      else $error("frame did not end after its last payload byte");

   a_count_below_length: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == afr_pkg::PH_OURS || phase_ff == afr_pkg::PH_OTHER) |-> seen_ff < len_ff)
      else $error("payload count reached the declared length inside a frame");

   a_history_cleared: assert property (@(posedge clock) disable iff (reset)
      phase_ff != afr_pkg::PH_HUNT |->
         (recent0_ff == 8'd0 && recent1_ff == 8'd0 && recent2_ff == 8'd0))
      else $error("byte history not cleared inside a frame");
`endif

endmodule

/* bench/addressed_frame_receiver_core_tb.sv */
module addressed_frame_receiver_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD = 128;
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   afr_req_if req_if ();
   afr_rsp_if rsp_if ();

   addressed_frame_receiver_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Parser state as the testbench believes it to be.
   logic [7:0] own_id;
   logic [2:0] parse_phase;
   logic [7:0] history [3];
   logic       frame_is_ours;
   logic [7:0] frame_len;
   logic [7:0] payload_count;

   afr_pkg::result_type expected_events [$];
   int         error_count = 0;
   bit         throttle = 1'b1;

   function automatic afr_pkg::result_type parse_rx_byte(input logic [7:0] b);
      afr_pkg::result_type res;
      logic [8:0] next_count;
      res = '0;
      next_count = {1'b0, payload_count} + 9'd1;
      case (parse_phase)
         afr_pkg::PH_ADDR: begin
            frame_is_ours = (b == own_id) || (b == 8'd0);
            parse_phase = afr_pkg::PH_LEN;
         end
         afr_pkg::PH_LEN: begin
            if (b < afr_pkg::MIN_LEN || b > MAX_LEN) begin
               frame_len = '0;
               parse_phase = afr_pkg::PH_HUNT;
            end else begin
               frame_len = b;
               payload_count = '0;
               parse_phase = frame_is_ours ? afr_pkg::PH_OURS : afr_pkg::PH_OTHER;
            end
         end
         afr_pkg::PH_OURS: begin
            res.hit = 1'b1;
            res.event_res = afr_pkg::EV_PAYLOAD;
            res.data_byte = b;
            res.byte_index = payload_count[6:0];
            res.frame_length = frame_len;
            res.last = (next_count >= {1'b0, frame_len});
            payload_count = next_count[7:0];
            if (res.last) begin
               payload_count = '0;
               parse_phase = afr_pkg::PH_HUNT;
            end
         end
         afr_pkg::PH_OTHER: begin
            if (next_count >= {1'b0, frame_len}) begin
               payload_count = '0;
               parse_phase = afr_pkg::PH_HUNT;
               res.hit = 1'b1;
               res.event_res = afr_pkg::EV_CTS;
               res.frame_length = frame_len;
            end else begin
               payload_count = next_count[7:0];
            end
         end
         default: begin
            parse_phase = afr_pkg::PH_HUNT;
            history[0] = history[1];
            history[1] = history[2];
            history[2] = b;
            // A frame start takes precedence over the info request check.
            if (history[1] == afr_pkg::CH_COLON && history[2] == afr_pkg::CH_COLON) begin
               history = '{8'h00, 8'h00, 8'h00};
               parse_phase = afr_pkg::PH_ADDR;
            end else if (history[0] == afr_pkg::CH_QUERY && history[1] == afr_pkg::CH_CR &&
                         history[2] == afr_pkg::CH_LF) begin
               res.hit = 1'b1;
               res.event_res = afr_pkg::EV_INFO;
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [7:0] noise_byte();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0: return afr_pkg::CH_COLON;
         1: return afr_pkg::CH_QUERY;
         2: return afr_pkg::CH_CR;
         3: return afr_pkg::CH_LF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_rx_byte(input logic [7:0] b);
      afr_pkg::result_type res;
      if (throttle && $urandom_range(99) < 28) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 28);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      res = parse_rx_byte(b);
      if (res.hit) expected_events.push_back(res);
   endtask

   // Bytes without a result may still be in flight when the queue empties.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_device_id(input logic [7:0] id);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= id;
      @(posedge clock);
      csr_we <= 1'b0;
      own_id = id;
   endtask

   task automatic send_frame(input logic [7:0] addr, input logic [7:0] len);
      send_rx_byte(afr_pkg::CH_COLON);
      send_rx_byte(afr_pkg::CH_COLON);
      send_rx_byte(addr);
      send_rx_byte(len);
      if (len >= afr_pkg::MIN_LEN && len <= MAX_LEN) begin
         repeat (len) send_rx_byte(noise_byte());
      end
   endtask

   always @(posedge clock) begin
      afr_pkg::result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected result transfer: event_res %0d", rsp_if.event_res);
               error_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_if.event_res !== want.event_res) begin
                  $error("event_res: expected %0d, actual %0d",
                         want.event_res, rsp_if.event_res);
                  error_count++;
               end
               if (rsp_if.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0d, actual %0d",
                         want.data_byte, rsp_if.data_byte);
                  error_count++;
               end
               if (rsp_if.byte_index !== want.byte_index) begin
                  $error("byte_index: expected %0d, actual %0d",
                         want.byte_index, rsp_if.byte_index);
                  error_count++;
               end
               if (rsp_if.frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, actual %0d",
                         want.frame_length, rsp_if.frame_length);
                  error_count++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_if.last);
                  error_count++;
               end
            end
         end
         rsp_if.ready <= !(throttle && $urandom_range(99) < 28);
      end
   end

   task automatic test_info_request();
      send_rx_byte(afr_pkg::CH_QUERY);
      send_rx_byte(afr_pkg::CH_CR);
      send_rx_byte(afr_pkg::CH_LF);
      drain_results();
   endtask

   task automatic test_own_frame();
      send_frame(8'd1, afr_pkg::MIN_LEN - 8'd2 + 8'd2);
      drain_results();
   endtask

   task automatic test_foreign_frame();
      // A query right before the start colons must not disturb the start.
      send_rx_byte(afr_pkg::CH_QUERY);
      send_frame(8'd5, afr_pkg::MIN_LEN);
      drain_results();
   endtask

   task automatic test_bad_length();
      send_frame(8'd1, afr_pkg::MIN_LEN - 8'd1);
      send_frame(8'd1, MAX_LEN + 8'd1);
      drain_results();
   endtask

   task automatic run_traffic(input int target);
      int         frame_bytes;
      int         pick;
      int         sel;
      int         count;
      logic [7:0] addr;
      logic [7:0] len;
      frame_bytes = 0;
      while (frame_bytes < target) begin
         pick = $urandom_range(99);
         if (pick < 68) begin
            sel = $urandom_range(9);
            if (sel < 4) addr = own_id;
            else if (sel < 6) addr = 8'd0;
            else addr = 8'($urandom_range(255));
            sel = $urandom_range(99);
            if (pick >= 60) begin
               if (sel < 30) len = 8'($urandom_range(1));
               else len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
            end else if (sel < 2) begin
               len = MAX_LEN;
            end else if (sel < 10) begin
               len = 8'($urandom_range(2, MAX_PAYLOAD));
            end else begin
               len = 8'($urandom_range(2, 12));
            end
            send_frame(addr, len);
            frame_bytes += 4;
            if (len >= afr_pkg::MIN_LEN && len <= MAX_LEN) frame_bytes += int'(len);
         end else if (pick < 80) begin
            send_rx_byte(afr_pkg::CH_QUERY);
            send_rx_byte(afr_pkg::CH_CR);
            send_rx_byte(afr_pkg::CH_LF);
            frame_bytes += 3;
         end else begin
            count = $urandom_range(1, 6);
            repeat (count) send_rx_byte(noise_byte());
         end
      end
   endtask

   task automatic test_random_traffic();
      set_device_id(8'hFF);
      run_traffic(450);
      set_device_id(8'h00);
      run_traffic(450);
      // One stretch with both sides running flat out.
      set_device_id(8'($urandom_range(2, 254)));
      throttle = 1'b0;
      run_traffic(450);
      drain_results();
      throttle = 1'b1;
      set_device_id(afr_pkg::CH_COLON);
      run_traffic(450);
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.rx_byte <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      reset <= 1'b1;
      own_id = 8'd1;
      parse_phase = afr_pkg::PH_HUNT;
      history = '{8'h00, 8'h00, 8'h00};
      frame_is_ours = 1'b0;
      frame_len = '0;
      payload_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_info_request();
      test_own_frame();
      test_foreign_frame();
      test_bad_length();
      test_random_traffic();
      drain_results();

      if (error_count == 0) begin
         $display("[addressed_frame_receiver_core] OK");
      end else begin
         $display("[addressed_frame_receiver_core] ERROR");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("[addressed_frame_receiver_core] ERROR");
      $finish;
   end

endmodule
